/* rtl/core/rgbcm_pkg.sv */
`timescale 1ns / 1ps

package rgbcm_pkg;

    // Mix weight: unsigned, 12 fraction bits, 4096 means one
    localparam int MIX_FRAC  = 12;
    localparam int MIX_WIDTH = 13;
    localparam int MIX_ONE   = 4096;

    localparam int REG_INDEX_WIDTH = 3;

    typedef enum logic [REG_INDEX_WIDTH-1:0] {
        REG_RED_ROW     = 3'd0,
        REG_GREEN_ROW   = 3'd1,
        REG_BLUE_ROW    = 3'd2,
        REG_CLAMP_BLACK = 3'd3,
        REG_CLAMP_WHITE = 3'd4,
        REG_MIX_WEIGHT  = 3'd5
    } reg_index_t;

    // Per-pixel control that travels alongside the lane pipelines
    typedef struct packed {
        logic valid;
        logic present;
    } ctl_t;

endpackage

/* rtl/core/rgbcm_lane.sv */
`timescale 1ns / 1ps

module rgbcm_lane
    import rgbcm_pkg::*;
#(
    parameter int CW = 16,
    parameter int KW = 18
)
(
    input  logic                   clk,
    input  logic [3*KW-1:0]        row,
    input  logic                   clamp_black,
    input  logic                   clamp_white,
    input  logic [MIX_WIDTH-1:0]   mix_weight,
    input  logic signed [CW-1:0]   chan_r,
    input  logic signed [CW-1:0]   chan_g,
    input  logic signed [CW-1:0]   chan_b,
    input  logic signed [CW-1:0]   orig,
    output logic signed [CW-1:0]   result
);

    localparam int PW = CW + KW;
    localparam int SW = PW + 2;
    localparam int MW = CW + MIX_WIDTH + 1;
    localparam int FW = MW + 1;

    localparam logic [63:0] CH_MAX_U = (64'd1 << (CW - 1)) - 64'd1;
    localparam logic signed [SW-1:0] CH_MAX = SW'(CH_MAX_U);
    localparam logic signed [SW-1:0] CH_MIN = SW'(~CH_MAX_U);
    localparam logic signed [SW-1:0] MAT_RND = SW'(64'd1 << (KW - 5));
    localparam logic signed [CW-1:0] CH_ONE = CW'(64'd1 << (CW - 4));
    localparam logic signed [MIX_WIDTH:0] MIX_ONE_S = (MIX_WIDTH + 1)'(MIX_ONE);
    localparam logic signed [FW-1:0] MIX_RND = FW'(64'd1 << (MIX_FRAC - 1));

    logic signed [CW-1:0] rgb [3];

    // stage 1: products
    logic signed [PW-1:0] prod_next [3];
    logic signed [PW-1:0] prod_reg  [3];
    logic signed [CW-1:0] orig1_reg;

    // stage 2: matrix result after rounding, saturation and clamping
    logic signed [SW-1:0] sum;
    logic signed [SW-1:0] shifted;
    logic signed [CW-1:0] sat;
    logic signed [CW-1:0] mat_next;
    logic signed [CW-1:0] mat_reg;
    logic signed [CW-1:0] orig2_reg;

    // stage 3: blend products
    logic signed [MIX_WIDTH:0] wt;
    logic signed [MIX_WIDTH:0] wo;
    logic signed [MW-1:0]      pt_next;
    logic signed [MW-1:0]      po_next;
    logic                      full_next;
    logic signed [MW-1:0]      pt_reg;
    logic signed [MW-1:0]      po_reg;
    logic                      full_reg;
    logic signed [CW-1:0]      mat3_reg;

    logic signed [FW-1:0]      fsum;
    logic signed [FW-1:0]      fshift;

    assign rgb[0] = chan_r;
    assign rgb[1] = chan_g;
    assign rgb[2] = chan_b;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            prod_next[k] = PW'($signed(row[k*KW +: KW])) * PW'(rgb[k]);
        end
    end

    always_comb
    begin
        sum     = SW'(prod_reg[0]) + SW'(prod_reg[1]) + SW'(prod_reg[2]);
        shifted = (sum + MAT_RND) >>> (KW - 4);
        if (shifted > CH_MAX)
        begin
            sat = CW'(CH_MAX);
        end
        else if (shifted < CH_MIN)
        begin
            sat = CW'(CH_MIN);
        end
        else
        begin
            sat = CW'(shifted);
        end
        mat_next = sat;
        if (clamp_black && (mat_next < 0))
        begin
            mat_next = '0;
        end
        if (clamp_white && (mat_next > CH_ONE))
        begin
            mat_next = CH_ONE;
        end
    end

    always_comb
    begin
        full_next = (mix_weight >= MIX_WIDTH'(MIX_ONE));
        wt        = $signed({1'b0, mix_weight});
        wo        = MIX_ONE_S - wt;
        pt_next   = MW'(mat_reg) * MW'(wt);
        po_next   = MW'(orig2_reg) * MW'(wo);
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            prod_reg[k] <= prod_next[k];
        end
        orig1_reg <= orig;
        mat_reg   <= mat_next;
        orig2_reg <= orig1_reg;
        pt_reg    <= pt_next;
        po_reg    <= po_next;
        full_reg  <= full_next;
        mat3_reg  <= mat_reg;
    end

    // round the blend to nearest, ties upward; it always lands in range
    assign fsum   = FW'(pt_reg) + FW'(po_reg) + MIX_RND;
    assign fshift = fsum >>> MIX_FRAC;
    assign result = full_reg ? mat3_reg : CW'(fshift);

endmodule

/* rtl/core/rgbcm_merge.sv */
`timescale 1ns / 1ps

module rgbcm_merge
    import rgbcm_pkg::*;
#(
    parameter int CW = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  ctl_t                 ctl,
    input  logic signed [CW-1:0] lane_red,
    input  logic signed [CW-1:0] lane_green,
    input  logic signed [CW-1:0] lane_blue,
    input  logic signed [CW-1:0] alpha,
    output logic                 done,
    output logic signed [CW-1:0] out_red,
    output logic signed [CW-1:0] out_green,
    output logic signed [CW-1:0] out_blue,
    output logic signed [CW-1:0] out_alpha
);

    logic                 done_reg;
    logic signed [CW-1:0] red_reg;
    logic signed [CW-1:0] green_reg;
    logic signed [CW-1:0] blue_reg;
    logic signed [CW-1:0] alpha_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= ctl.valid;
        end
    end

    // drop everything to zero for a pixel outside the source
    always_ff @(posedge clk)
    begin
        red_reg   <= ctl.present ? lane_red   : '0;
        green_reg <= ctl.present ? lane_green : '0;
        blue_reg  <= ctl.present ? lane_blue  : '0;
        alpha_reg <= ctl.present ? alpha      : '0;
    end

    assign done      = done_reg;
    assign out_red   = red_reg;
    assign out_green = green_reg;
    assign out_blue  = blue_reg;
    assign out_alpha = alpha_reg;

endmodule

/* rtl/core/rgb_color_matrix_clamp_mix.sv */
`timescale 1ns / 1ps
// A pixel transferred at a clock edge passes the three lane stages and then the merge register
// before it appears on the result ports with done high.
// Throughput: one pixel per clock, set by the three fully pipelined channel lanes; busy stays low.
// Reset (rst_n, asynchronous, active low) empties the pipeline and loads the identity matrix,
// clamp black on, clamp white off and a mix weight of one. Results cannot be stalled.

module rgb_color_matrix_clamp_mix
    import rgbcm_pkg::*;
#(
    parameter int CHANNEL_WIDTH = 16,
    parameter int COEFF_WIDTH   = 18
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    // pixel command
    input  logic                            start,
    output logic                            busy,
    input  logic                            src_present,
    input  logic signed [CHANNEL_WIDTH-1:0] in_red,
    input  logic signed [CHANNEL_WIDTH-1:0] in_green,
    input  logic signed [CHANNEL_WIDTH-1:0] in_blue,
    input  logic signed [CHANNEL_WIDTH-1:0] in_alpha,
    // result
    output logic                            done,
    output logic signed [CHANNEL_WIDTH-1:0] out_red,
    output logic signed [CHANNEL_WIDTH-1:0] out_green,
    output logic signed [CHANNEL_WIDTH-1:0] out_blue,
    output logic signed [CHANNEL_WIDTH-1:0] out_alpha,
    // configuration writes
    input  logic                            wr_en,
    input  logic [REG_INDEX_WIDTH-1:0]      wr_index,
    input  logic [3*COEFF_WIDTH-1:0]        wr_data
);

    localparam int CW = CHANNEL_WIDTH;
    localparam int KW = COEFF_WIDTH;
    localparam int RW = 3 * KW;

    // Coefficient one has KW-4 fraction bits; identity rows reset along the diagonal.
    localparam logic [RW-1:0] COEFF_ONE   = RW'(64'd1 << (KW - 4));
    localparam logic [RW-1:0] RED_RESET   = COEFF_ONE;
    localparam logic [RW-1:0] GREEN_RESET = COEFF_ONE << KW;
    localparam logic [RW-1:0] BLUE_RESET  = COEFF_ONE << (2 * KW);

    // ------------------------------------------------------------------
    // Configuration registers. Software must write them only while no pixel is in
    // flight; the block does not enforce this. The lanes read them directly without shadowing.
    // ------------------------------------------------------------------
    logic [RW-1:0]        red_row_reg;
    logic [RW-1:0]        green_row_reg;
    logic [RW-1:0]        blue_row_reg;
    logic                 clamp_black_reg;
    logic                 clamp_white_reg;
    logic [MIX_WIDTH-1:0] mix_weight_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            red_row_reg     <= RED_RESET;
            green_row_reg   <= GREEN_RESET;
            blue_row_reg    <= BLUE_RESET;
            clamp_black_reg <= 1'b1;
            clamp_white_reg <= 1'b0;
            mix_weight_reg  <= MIX_WIDTH'(MIX_ONE);
        end
        else if (wr_en)
        begin
            // unknown indexes are ignored
            case (reg_index_t'(wr_index))
                REG_RED_ROW:     red_row_reg     <= wr_data;
                REG_GREEN_ROW:   green_row_reg   <= wr_data;
                REG_BLUE_ROW:    blue_row_reg    <= wr_data;
                REG_CLAMP_BLACK: clamp_black_reg <= wr_data[0];
                REG_CLAMP_WHITE: clamp_white_reg <= wr_data[0];
                REG_MIX_WEIGHT:  mix_weight_reg  <= wr_data[MIX_WIDTH-1:0];
                default:         ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Input transfer. Every stage advances every cycle, so a new pixel is
    // always welcome and busy is tied low.
    // ------------------------------------------------------------------
    logic accept;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Control and alpha ride alongside the three lane stages.
    ctl_t                 ctl_next;
    ctl_t                 ctl1_reg;
    ctl_t                 ctl2_reg;
    ctl_t                 ctl3_reg;
    logic signed [CW-1:0] alpha1_reg;
    logic signed [CW-1:0] alpha2_reg;
    logic signed [CW-1:0] alpha3_reg;

    always_comb
    begin
        ctl_next.valid   = accept;
        ctl_next.present = src_present;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
            ctl3_reg <= '0;
        end
        else
        begin
            ctl1_reg <= ctl_next;
            ctl2_reg <= ctl1_reg;
            ctl3_reg <= ctl2_reg;
        end
    end

    // payload: no reset needed, the valid flag qualifies it
    always_ff @(posedge clk)
    begin
        alpha1_reg <= in_alpha;
        alpha2_reg <= alpha1_reg;
        alpha3_reg <= alpha2_reg;
    end

    // ------------------------------------------------------------------
    // One lane per output channel: products, then sum with rounding,
    // saturation and clamping, then the blend with the original channel.
    // ------------------------------------------------------------------
    logic signed [CW-1:0] lane_red;
    logic signed [CW-1:0] lane_green;
    logic signed [CW-1:0] lane_blue;

    rgbcm_lane #(.CW(CW), .KW(KW)) u_lane_red
    (
        .clk         (clk),
        .row         (red_row_reg),
        .clamp_black (clamp_black_reg),
        .clamp_white (clamp_white_reg),
        .mix_weight  (mix_weight_reg),
        .chan_r      (in_red),
        .chan_g      (in_green),
        .chan_b      (in_blue),
        .orig        (in_red),
        .result      (lane_red)
    );

    rgbcm_lane #(.CW(CW), .KW(KW)) u_lane_green
    (
        .clk         (clk),
        .row         (green_row_reg),
        .clamp_black (clamp_black_reg),
        .clamp_white (clamp_white_reg),
        .mix_weight  (mix_weight_reg),
        .chan_r      (in_red),
        .chan_g      (in_green),
        .chan_b      (in_blue),
        .orig        (in_green),
        .result      (lane_green)
    );

    rgbcm_lane #(.CW(CW), .KW(KW)) u_lane_blue
    (
        .clk         (clk),
        .row         (blue_row_reg),
        .clamp_black (clamp_black_reg),
        .clamp_white (clamp_white_reg),
        .mix_weight  (mix_weight_reg),
        .chan_r      (in_red),
        .chan_g      (in_green),
        .chan_b      (in_blue),
        .orig        (in_blue),
        .result      (lane_blue)
    );

    // ------------------------------------------------------------------
    // Merge: gather the lanes and alpha, zero a pixel outside the source,
    // and hold the result for its single-cycle transfer.
    // ------------------------------------------------------------------
    rgbcm_merge #(.CW(CW)) u_merge
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl3_reg),
        .lane_red   (lane_red),
        .lane_green (lane_green),
        .lane_blue  (lane_blue),
        .alpha      (alpha3_reg),
        .done       (done),
        .out_red    (out_red),
        .out_green  (out_green),
        .out_blue   (out_blue),
        .out_alpha  (out_alpha)
    );

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    a_done_follows_accept : assert property (
        @(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, 4)
    ) else $error("result transfer without a pixel accepted four cycles earlier");

    a_accept_gives_done : assert property (
        @(posedge clk) disable iff (!rst_n)
        accept |-> ##4 done
    ) else $error("accepted pixel produced no result after four cycles");

    a_absent_is_zero : assert property (
        @(posedge clk) disable iff (!rst_n)
        (accept && !src_present) |-> ##4 (out_red == '0 && out_green == '0 &&
                                          out_blue == '0 && out_alpha == '0)
    ) else $error("pixel outside the source did not give an all-zero result");

endmodule
